// ===== hw/rtl/pmcd_pkg.sv =====
`default_nettype none

package pmcd_pkg;

  // Map geometry
  localparam int MAP_WIDTH  = 1024;
  localparam int MAP_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAP_WIDTH);
  localparam int ROW_W      = $clog2(MAP_HEIGHT);
  localparam int ADDR_W     = ROW_W + COL_W;
  localparam int MEM_DEPTH  = MAP_HEIGHT << COL_W;
  localparam int MAX_DIM    = (MAP_WIDTH > MAP_HEIGHT) ? MAP_WIDTH : MAP_HEIGHT;

  // Field widths
  localparam int ACTION_W  = 2;
  localparam int COORD_W   = 16;
  localparam int CELL_W    = 8;
  localparam int DIST_W    = 16;
  localparam int IN_DATA_W = 4 * COORD_W + CELL_W;

  // Configuration registers
  localparam int SCALE_W    = 5;
  localparam int ORIGIN_W   = 15;
  localparam int LIMIT_W    = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS   = 2'd3;

  localparam logic [SCALE_W-1:0]  SCALE_RESET  = 5'd1;
  localparam logic [ORIGIN_W-1:0] ORIGIN_RESET = 15'd0;
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 11'd1024;

  // Divider
  localparam int DIV_W     = 16;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // Walk accumulators and final scaling
  localparam int WRONG_WAY_COST = 4;
  localparam int STEP_SHIFT     = $clog2(WRONG_WAY_COST);
  localparam int COST_W         = $clog2(WRONG_WAY_COST * MAX_DIM);
  localparam int STEP_W         = $clog2(MAX_DIM);
  localparam int PCOST_W        = COST_W + SCALE_W;
  localparam int PSTEP_W        = STEP_W + SCALE_W;
  localparam int SUM_W          = ((PCOST_W > DIST_W) ? PCOST_W : DIST_W) + 1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE = 2'd0,
    ACT_BUMP  = 2'd1,
    ACT_VERT  = 2'd2,
    ACT_HORZ  = 2'd3
  } action_e;

  // Conversion slot: bit 0 selects row, bit 1 selects the second point
  localparam logic [1:0] SEL_COL_A = 2'd0;
  localparam logic [1:0] SEL_ROW_A = 2'd1;
  localparam logic [1:0] SEL_COL_B = 2'd2;
  localparam logic [1:0] SEL_ROW_B = 2'd3;

  typedef struct packed {
    logic       clear;
    logic       accept;
    logic       div_start;
    logic       div_store;
    logic [1:0] div_sel;
    logic       write_cell;
    logic       rect_init;
    logic       rect_rd;
    logic       rect_wr;
    logic       walk_init;
    logic       walk_step;
    logic       fin_mul;
    logic       fin_add;
    logic       load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    action_e action;
    logic    clear_last;
    logic    div_done;
    logic    rect_empty;
    logic    rect_last;
    logic    same_cell;
    logic    at_end;
    logic    out_full;
  } ctrl_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pmcd_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module pmcd_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [pmcd_pkg::DIV_W-1:0]    num_i,
  input  wire logic [pmcd_pkg::SCALE_W-1:0]  den_i,
  output logic                               done_o,
  output logic [pmcd_pkg::DIV_W-1:0]         quot_o
);

  logic                               busy_q;
  logic                               done_q;
  logic [pmcd_pkg::DIV_CNT_W-1:0]     cnt_q;
  logic [pmcd_pkg::DIV_W-1:0]         quo_q;
  logic [pmcd_pkg::SCALE_W-1:0]       rem_q;
  logic [pmcd_pkg::SCALE_W-1:0]       den_q;
  logic [pmcd_pkg::SCALE_W:0]         trial;
  logic [pmcd_pkg::SCALE_W:0]         diff;
  logic                               ge;

  assign trial = {rem_q, quo_q[pmcd_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= pmcd_pkg::DIV_CNT_W'(pmcd_pkg::DIV_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[pmcd_pkg::DIV_W-2:0], ge};
      rem_q <= ge ? diff[pmcd_pkg::SCALE_W-1:0] : trial[pmcd_pkg::SCALE_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

// ===== hw/rtl/pmcd_dp.sv =====
`default_nettype none

module pmcd_dp (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire pmcd_pkg::ctrl_cmd_t              cmd_i,
  output pmcd_pkg::ctrl_status_t                status_o,
  input  wire logic [pmcd_pkg::IN_DATA_W-1:0]   in_data_i,
  input  wire logic [pmcd_pkg::ACTION_W-1:0]    in_user_i,
  input  wire logic                             cfg_we_i,
  input  wire logic [pmcd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [pmcd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                             out_ready_i,
  output logic                                  out_valid_o,
  output logic [pmcd_pkg::DIST_W-1:0]           out_dist_o
);

  localparam int CW = pmcd_pkg::COORD_W;

  // Configuration
  logic [pmcd_pkg::SCALE_W-1:0]  scale_q;
  logic [pmcd_pkg::ORIGIN_W-1:0] origin_q;
  logic [pmcd_pkg::LIMIT_W-1:0]  cols_q;
  logic [pmcd_pkg::LIMIT_W-1:0]  rows_q;
  logic [pmcd_pkg::SCALE_W-1:0]  scale_eff;
  logic [pmcd_pkg::COL_W-1:0]    col_hi;
  logic [pmcd_pkg::ROW_W-1:0]    row_hi;

  // Request
  pmcd_pkg::action_e             action_q;
  logic signed [CW-1:0]          x1_q, y1_q, x2_q, y2_q;
  logic [pmcd_pkg::CELL_W-1:0]   val_q;

  // Mapped cells and walk position
  logic [pmcd_pkg::COL_W-1:0]    col_a_q, col_b_q, cur_col_q;
  logic [pmcd_pkg::ROW_W-1:0]    row_a_q, row_b_q, cur_row_q;

  // Divider hookup
  logic signed [CW-1:0]          num_x, num_y;
  logic signed [CW+1:0]          row_diff;
  logic [pmcd_pkg::DIV_W-1:0]    div_num;
  logic [pmcd_pkg::DIV_W-1:0]    quot;
  logic                          div_done;
  logic [pmcd_pkg::COL_W-1:0]    col_clip;
  logic [pmcd_pkg::ROW_W-1:0]    row_clip;

  // Map memory
  logic [pmcd_pkg::CELL_W-1:0]   mem [pmcd_pkg::MEM_DEPTH];
  logic [pmcd_pkg::ADDR_W-1:0]   clr_q;
  logic [pmcd_pkg::ADDR_W-1:0]   waddr;
  logic [pmcd_pkg::CELL_W-1:0]   wdata;
  logic                          we;
  logic                          rd_en;
  logic [pmcd_pkg::CELL_W-1:0]   rdata_q;
  logic                          in_map;

  // Walk accumulators
  logic                          rvalid_q;
  logic                          first_q;
  logic [pmcd_pkg::CELL_W-1:0]   prev_q;
  logic [pmcd_pkg::COST_W-1:0]   cost_q;
  logic [pmcd_pkg::STEP_W-1:0]   steps_q;
  logic [pmcd_pkg::PCOST_W-1:0]  pcost_q;
  logic [pmcd_pkg::PSTEP_W-1:0]  pstep_q;
  logic [pmcd_pkg::SUM_W-1:0]    sum;
  logic [pmcd_pkg::DIST_W-1:0]   dist_q;

  logic                          out_valid_q;
  logic [pmcd_pkg::DIST_W-1:0]   out_dist_q;
  logic                          vert;

  // ---------------------------------------------------------------------------
  // Configuration registers and derived limits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= pmcd_pkg::SCALE_RESET;
      origin_q <= pmcd_pkg::ORIGIN_RESET;
      cols_q   <= pmcd_pkg::LIMIT_RESET;
      rows_q   <= pmcd_pkg::LIMIT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pmcd_pkg::REG_SCALE:  scale_q  <= cfg_data_i[pmcd_pkg::SCALE_W-1:0];
        pmcd_pkg::REG_ORIGIN: origin_q <= cfg_data_i[pmcd_pkg::ORIGIN_W-1:0];
        pmcd_pkg::REG_COLS:   cols_q   <= cfg_data_i[pmcd_pkg::LIMIT_W-1:0];
        pmcd_pkg::REG_ROWS:   rows_q   <= cfg_data_i[pmcd_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign scale_eff = (scale_q == '0) ? pmcd_pkg::SCALE_W'(1) : scale_q;

  // Last usable column and row after clamping to [1, map size]
  always_comb begin
    if (cols_q == '0) begin
      col_hi = '0;
    end else if (32'(cols_q) > 32'(pmcd_pkg::MAP_WIDTH)) begin
      col_hi = pmcd_pkg::COL_W'(pmcd_pkg::MAP_WIDTH - 1);
    end else begin
      col_hi = pmcd_pkg::COL_W'(cols_q - 1'b1);
    end
    if (rows_q == '0) begin
      row_hi = '0;
    end else if (32'(rows_q) > 32'(pmcd_pkg::MAP_HEIGHT)) begin
      row_hi = pmcd_pkg::ROW_W'(pmcd_pkg::MAP_HEIGHT - 1);
    end else begin
      row_hi = pmcd_pkg::ROW_W'(rows_q - 1'b1);
    end
  end

  // ---------------------------------------------------------------------------
  // Request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      action_q <= pmcd_pkg::action_e'(in_user_i);
      x1_q     <= in_data_i[CW-1:0];
      y1_q     <= in_data_i[2*CW-1:CW];
      x2_q     <= in_data_i[3*CW-1:2*CW];
      y2_q     <= in_data_i[4*CW-1:3*CW];
      val_q    <= in_data_i[pmcd_pkg::IN_DATA_W-1:4*CW];
    end
  end

  assign vert = (action_q == pmcd_pkg::ACT_VERT);

  // ---------------------------------------------------------------------------
  // Coordinate to cell conversion; negative quotients clip to zero, so a
  // negative numerator is fed as zero.
  assign num_x    = cmd_i.div_sel[1] ? x2_q : x1_q;
  assign num_y    = cmd_i.div_sel[1] ? y2_q : y1_q;
  assign row_diff = $signed({3'b000, origin_q}) - $signed({{2{num_y[CW-1]}}, num_y});

  always_comb begin
    if (cmd_i.div_sel[0]) begin
      div_num = row_diff[CW+1] ? '0 : row_diff[pmcd_pkg::DIV_W-1:0];
    end else begin
      div_num = num_x[CW-1] ? '0 : pmcd_pkg::DIV_W'(num_x[CW-2:0]);
    end
  end

  pmcd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (scale_eff),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign col_clip = (quot > pmcd_pkg::DIV_W'(col_hi)) ? col_hi : quot[pmcd_pkg::COL_W-1:0];
  assign row_clip = (quot > pmcd_pkg::DIV_W'(row_hi)) ? row_hi : quot[pmcd_pkg::ROW_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_store) begin
      unique case (cmd_i.div_sel)
        pmcd_pkg::SEL_COL_A: col_a_q <= col_clip;
        pmcd_pkg::SEL_ROW_A: row_a_q <= row_clip;
        pmcd_pkg::SEL_COL_B: col_b_q <= col_clip;
        pmcd_pkg::SEL_ROW_B: row_b_q <= row_clip;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Position: rectangle scan (row major) or walk toward the end cell
  always_ff @(posedge clk_i) begin
    if (cmd_i.rect_init || cmd_i.walk_init) begin
      cur_row_q <= row_a_q;
      cur_col_q <= col_a_q;
    end else if (cmd_i.rect_wr) begin
      if (cur_col_q == col_b_q) begin
        cur_col_q <= col_a_q;
        cur_row_q <= cur_row_q + 1'b1;
      end else begin
        cur_col_q <= cur_col_q + 1'b1;
      end
    end else if (cmd_i.walk_step) begin
      if (vert) begin
        if (cur_row_q < row_b_q) begin
          cur_row_q <= cur_row_q + 1'b1;
        end else if (cur_row_q > row_b_q) begin
          cur_row_q <= cur_row_q - 1'b1;
        end
      end else begin
        if (cur_col_q < col_b_q) begin
          cur_col_q <= cur_col_q + 1'b1;
        end else if (cur_col_q > col_b_q) begin
          cur_col_q <= cur_col_q - 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Map memory: one write and one registered read per cycle
  assign in_map = !x1_q[CW-1] && !y1_q[CW-1]
               && (32'(x1_q[CW-2:0]) <= 32'(col_hi))
               && (32'(y1_q[CW-2:0]) <= 32'(row_hi));

  always_comb begin
    waddr = {cur_row_q, cur_col_q};
    wdata = (rdata_q == '1) ? rdata_q : rdata_q + 1'b1;
    we    = cmd_i.rect_wr;
    if (cmd_i.clear) begin
      waddr = clr_q;
      wdata = '0;
      we    = 1'b1;
    end else if (cmd_i.write_cell) begin
      waddr = {y1_q[pmcd_pkg::ROW_W-1:0], x1_q[pmcd_pkg::COL_W-1:0]};
      wdata = val_q;
      we    = in_map;
    end
  end

  assign rd_en = cmd_i.rect_rd || cmd_i.walk_step;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[{cur_row_q, cur_col_q}];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q    <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        clr_q <= clr_q + 1'b1;
      end
      rvalid_q <= cmd_i.walk_step;
    end
  end

  // ---------------------------------------------------------------------------
  // Walk tally; the first cell read only seeds the previous value
  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_init) begin
      first_q <= 1'b1;
      cost_q  <= '0;
      steps_q <= '0;
    end else if (rvalid_q) begin
      prev_q  <= rdata_q;
      first_q <= 1'b0;
      if (!first_q) begin
        if (rdata_q < prev_q) begin
          cost_q <= cost_q + pmcd_pkg::COST_W'(pmcd_pkg::WRONG_WAY_COST);
        end else if (rdata_q > prev_q) begin
          steps_q <= steps_q + 1'b1;
        end else begin
          cost_q <= cost_q + 1'b1;
        end
      end
    end
  end

  // Scaling: multiply, then add and saturate
  assign sum = pmcd_pkg::SUM_W'(pcost_q) + pmcd_pkg::SUM_W'(pstep_q >> pmcd_pkg::STEP_SHIFT);

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_mul) begin
      pcost_q <= pmcd_pkg::PCOST_W'(cost_q) * pmcd_pkg::PCOST_W'(scale_eff);
      pstep_q <= pmcd_pkg::PSTEP_W'(steps_q) * pmcd_pkg::PSTEP_W'(scale_eff);
    end
    if (cmd_i.accept) begin
      dist_q <= '0;
    end else if (cmd_i.fin_add) begin
      dist_q <= (sum > pmcd_pkg::SUM_W'({pmcd_pkg::DIST_W{1'b1}}))
              ? '1 : sum[pmcd_pkg::DIST_W-1:0];
    end
    if (cmd_i.load_out) begin
      out_dist_q <= dist_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_dist_o  = out_dist_q;

  // ---------------------------------------------------------------------------
  // Status
  always_comb begin
    status_o.action     = action_q;
    status_o.clear_last = (clr_q == pmcd_pkg::ADDR_W'(pmcd_pkg::MEM_DEPTH - 1));
    status_o.div_done   = div_done;
    status_o.rect_empty = (col_a_q > col_b_q) || (row_a_q > row_b_q);
    status_o.rect_last  = (cur_col_q == col_b_q) && (cur_row_q == row_b_q);
    status_o.same_cell  = vert ? (row_a_q == row_b_q) : (col_a_q == col_b_q);
    status_o.at_end     = vert ? (cur_row_q == row_b_q) : (cur_col_q == col_b_q);
    status_o.out_full   = out_valid_q && !out_ready_i;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pmcd_ctrl.sv =====
`default_nettype none

module pmcd_ctrl (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire pmcd_pkg::ctrl_status_t  status_i,
  output pmcd_pkg::ctrl_cmd_t          cmd_o
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_WRITE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_RECT_INIT,
    ST_RECT_RD,
    ST_RECT_WR,
    ST_WALK_INIT,
    ST_WALK,
    ST_WALK_DRAIN,
    ST_FIN_MUL,
    ST_FIN_ADD,
    ST_DONE
  } state_e;

  state_e     state_q;
  logic [1:0] sel_q;
  logic       ready_q;
  logic       accept;

  assign accept     = in_valid_i && ready_q;
  assign in_ready_o = ready_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      sel_q   <= '0;
      ready_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_CLEAR: begin
          if (status_i.clear_last) begin
            state_q <= ST_IDLE;
            ready_q <= 1'b1;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_DECODE;
            ready_q <= 1'b0;
          end
        end
        ST_DECODE: begin
          sel_q <= pmcd_pkg::SEL_COL_A;
          if (status_i.action == pmcd_pkg::ACT_WRITE) begin
            state_q <= ST_WRITE;
          end else begin
            state_q <= ST_DIV_START;
          end
        end
        ST_WRITE:     state_q <= ST_DONE;
        ST_DIV_START: state_q <= ST_DIV_WAIT;
        ST_DIV_WAIT: begin
          if (status_i.div_done) begin
            if (sel_q == pmcd_pkg::SEL_ROW_B) begin
              if (status_i.action == pmcd_pkg::ACT_BUMP) begin
                state_q <= ST_RECT_INIT;
              end else begin
                state_q <= ST_WALK_INIT;
              end
            end else begin
              sel_q   <= sel_q + 1'b1;
              state_q <= ST_DIV_START;
            end
          end
        end
        ST_RECT_INIT: state_q <= status_i.rect_empty ? ST_DONE : ST_RECT_RD;
        ST_RECT_RD:   state_q <= ST_RECT_WR;
        ST_RECT_WR:   state_q <= status_i.rect_last ? ST_DONE : ST_RECT_RD;
        ST_WALK_INIT: state_q <= status_i.same_cell ? ST_FIN_MUL : ST_WALK;
        ST_WALK: begin
          if (status_i.at_end) begin
            state_q <= ST_WALK_DRAIN;
          end
        end
        ST_WALK_DRAIN: state_q <= ST_FIN_MUL;
        ST_FIN_MUL:    state_q <= ST_FIN_ADD;
        ST_FIN_ADD:    state_q <= ST_DONE;
        ST_DONE: begin
          if (!status_i.out_full) begin
            state_q <= ST_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: state_q <= ST_CLEAR;
      endcase
    end
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.accept     = accept;
    cmd_o.div_sel    = sel_q;
    cmd_o.clear      = (state_q == ST_CLEAR);
    cmd_o.write_cell = (state_q == ST_WRITE);
    cmd_o.div_start  = (state_q == ST_DIV_START);
    cmd_o.div_store  = (state_q == ST_DIV_WAIT) && status_i.div_done;
    cmd_o.rect_init  = (state_q == ST_RECT_INIT);
    cmd_o.rect_rd    = (state_q == ST_RECT_RD);
    cmd_o.rect_wr    = (state_q == ST_RECT_WR);
    cmd_o.walk_init  = (state_q == ST_WALK_INIT);
    cmd_o.walk_step  = (state_q == ST_WALK);
    cmd_o.fin_mul    = (state_q == ST_FIN_MUL);
    cmd_o.fin_add    = (state_q == ST_FIN_ADD);
    cmd_o.load_out   = (state_q == ST_DONE) && !status_i.out_full;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/projection_map_curved_distance.sv =====
`default_nettype none

// Density map with curved-distance measurement. One request at a time: a
// cell write stores one cell; rectangle increment and both distance walks
// first map four coordinates, one after another, through a shared
// bit-serial divider. A rectangle then reads each cell and writes it back
// incremented through the single map write port, and a walk reads each cell
// it visits and then scales the result (multiply, then add and saturate).
// The map is one 8-bit memory of MAP_HEIGHT x 2^clog2(MAP_WIDTH) cells;
// after reset it is zeroed one cell per cycle, and no request is taken
// until that sweep over the whole map ends.
// Config writes are accepted at any time and must only be issued while idle.
// A result waits in an output register, so the next request can be taken
// before the previous distance has been consumed.
module projection_map_curved_distance (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // coord_x1 [15:0], coord_y1 [31:16], coord_x2 [47:32], coord_y2 [63:48],
  // cell_value [71:64]
  input  wire logic [pmcd_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // action [1:0]
  input  wire logic [pmcd_pkg::ACTION_W-1:0]    s_axis_tuser_i,
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // distance [15:0]
  output logic [pmcd_pkg::DIST_W-1:0]           m_axis_tdata_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [pmcd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [pmcd_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  pmcd_pkg::ctrl_cmd_t    cmd;
  pmcd_pkg::ctrl_status_t status;

  assign cfg_ready_o = 1'b1;

  pmcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pmcd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (s_axis_tdata_i),
    .in_user_i   (s_axis_tuser_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_dist_o  (m_axis_tdata_o)
  );

  // A result must never overwrite one still waiting at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> !(m_axis_tvalid_o && !m_axis_tready_i))
    else $error("result loaded into a full output register");

  // The map port is busy with clearing or update only outside of request intake.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |-> !(cmd.clear || cmd.rect_wr || cmd.write_cell))
    else $error("request taken while the map is being written");

  // One request in flight at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("second request taken before the first was finished");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none

module tb;
  import pmcd_pkg::*;

  localparam int     HOLD_CYCLES = 1500;
  localparam longint DIST_LIMIT  = (longint'(1) << DIST_W) - 1;

  typedef struct {
    action_e                   act;
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic signed [COORD_W-1:0] x2;
    logic signed [COORD_W-1:0] y2;
    logic [CELL_W-1:0]         cell_val;
  } map_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic [ACTION_W-1:0]   s_axis_tuser_i = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [DIST_W-1:0]     m_axis_tdata_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  projection_map_curved_distance uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Mirror of the map and of the registers, updated as requests are taken
  bit [CELL_W-1:0] density_mirror [MAP_HEIGHT][MAP_WIDTH];
  int cfg_scale  = int'(SCALE_RESET);
  int cfg_origin = int'(ORIGIN_RESET);
  int cfg_cols   = int'(LIMIT_RESET);
  int cfg_rows   = int'(LIMIT_RESET);

  logic [DIST_W-1:0] pending_distance [$];
  logic [DIST_W-1:0] exp_dist;
  int errors = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit tx_offering = 1'b0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  function automatic int eff_scale();
    return (cfg_scale == 0) ? 1 : cfg_scale;
  endfunction

  function automatic int cols_in_use();
    return (cfg_cols < 1) ? 1 : (cfg_cols > MAP_WIDTH) ? MAP_WIDTH : cfg_cols;
  endfunction

  function automatic int rows_in_use();
    return (cfg_rows < 1) ? 1 : (cfg_rows > MAP_HEIGHT) ? MAP_HEIGHT : cfg_rows;
  endfunction

  function automatic int clip(int v, int hi);
    return (v < 0) ? 0 : (v > hi) ? hi : v;
  endfunction

  function automatic int col_of(int x);
    return clip(x / eff_scale(), cols_in_use() - 1);
  endfunction

  function automatic int row_of(int y);
    return clip((cfg_origin - y) / eff_scale(), rows_in_use() - 1);
  endfunction

  function automatic logic [DIST_W-1:0] walk_distance(bit vertical, int lane, int p1, int p2);
    longint cost, steps, d;
    int dir, p;
    logic [CELL_W-1:0] prev, cur;
    cost = 0;
    steps = 0;
    if (p1 == p2) return '0;
    dir = (p1 < p2) ? 1 : -1;
    prev = vertical ? density_mirror[p1][lane] : density_mirror[lane][p1];
    for (p = p1; p != p2; p += dir) begin
      cur = vertical ? density_mirror[p + dir][lane] : density_mirror[lane][p + dir];
      if (cur < prev) cost += WRONG_WAY_COST;
      else if (cur > prev) steps++;
      else cost++;
      prev = cur;
    end
    d = cost * eff_scale() + (steps * eff_scale()) / WRONG_WAY_COST;
    return (d > DIST_LIMIT) ? {DIST_W{1'b1}} : d[DIST_W-1:0];
  endfunction

  function automatic logic [DIST_W-1:0] predict_distance(map_req_t r);
    int x1, y1, x2, y2, left, right, top, bottom, row, col;
    logic [DIST_W-1:0] result_dist;
    x1 = r.x1;
    y1 = r.y1;
    x2 = r.x2;
    y2 = r.y2;
    result_dist = '0;
    case (r.act)
      ACT_WRITE: begin
        // raw cell indices, no scaling
        if (x1 >= 0 && x1 < cols_in_use() && y1 >= 0 && y1 < rows_in_use())
          density_mirror[y1][x1] = r.cell_val;
      end
      ACT_BUMP: begin
        left = col_of(x1);
        right = col_of(x2);
        top = row_of(y1);
        bottom = row_of(y2);
        for (row = top; row <= bottom; row++)
          for (col = left; col <= right; col++)
            if (density_mirror[row][col] != 8'hFF) density_mirror[row][col]++;
      end
      ACT_VERT: result_dist = walk_distance(1'b1, col_of(x1), row_of(y1), row_of(y2));
      default:  result_dist = walk_distance(1'b0, row_of(y1), col_of(x1), col_of(x2));
    endcase
    return result_dist;
  endfunction

  task automatic report_mismatch(string what, logic [DIST_W-1:0] got, logic [DIST_W-1:0] want);
    $display("MISMATCH at %0t: %s, got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  // Receiver: checks each result, idles at random, honors long hold-offs
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_distance.size() == 0) begin
        report_mismatch("result with no request pending", m_axis_tdata_o, '0);
      end else begin
        exp_dist = pending_distance.pop_front();
        if (m_axis_tdata_o !== exp_dist) report_mismatch("distance", m_axis_tdata_o, exp_dist);
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= (int'($urandom_range(0, 99)) >= rx_idle_pct);
    end
  end

  task automatic issue(action_e act, int x1, int y1, int x2, int y2, int cell_val);
    map_req_t r;
    r.act = act;
    r.x1 = x1[COORD_W-1:0];
    r.y1 = y1[COORD_W-1:0];
    r.x2 = x2[COORD_W-1:0];
    r.y2 = y2[COORD_W-1:0];
    r.cell_val = cell_val[CELL_W-1:0];
    while (int'($urandom_range(0, 99)) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {r.cell_val, r.y2, r.x2, r.y1, r.x1};
    s_axis_tuser_i  <= r.act;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    tx_offering = 1'b1;
    pending_distance.push_back(predict_distance(r));
  endtask

  task automatic wait_results();
    if (tx_offering) begin
      s_axis_tvalid_i <= 1'b0;
      tx_offering = 1'b0;
    end
    while (pending_distance.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, int value);
    logic [CFG_DATA_W-1:0] data;
    // unused upper bits carry noise, the block must drop them
    data = CFG_DATA_W'($urandom());
    case (index)
      REG_SCALE:  data[SCALE_W-1:0]  = value[SCALE_W-1:0];
      REG_ORIGIN: data[ORIGIN_W-1:0] = value[ORIGIN_W-1:0];
      default:    data[LIMIT_W-1:0]  = value[LIMIT_W-1:0];
    endcase
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (index)
      REG_SCALE:  cfg_scale  = int'(data[SCALE_W-1:0]);
      REG_ORIGIN: cfg_origin = int'(data[ORIGIN_W-1:0]);
      REG_COLS:   cfg_cols   = int'(data[LIMIT_W-1:0]);
      default:    cfg_rows   = int'(data[LIMIT_W-1:0]);
    endcase
  endtask

  // Only while idle: callers drain all results first
  task automatic program_map(int scale, int origin, int cols, int rows);
    write_reg(REG_SCALE, scale);
    write_reg(REG_ORIGIN, origin);
    write_reg(REG_COLS, cols);
    write_reg(REG_ROWS, rows);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic int rnd16();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  // Image x mostly around the map in use, sometimes anywhere
  function automatic int rand_x();
    int span;
    span = cols_in_use() * eff_scale();
    if ($urandom_range(0, 9) == 0) return rnd16();
    return int'($urandom_range(0, span + 2 * eff_scale())) - eff_scale();
  endfunction

  function automatic int rand_y();
    int span;
    span = rows_in_use() * eff_scale();
    if ($urandom_range(0, 9) == 0) return rnd16();
    return cfg_origin + eff_scale() - int'($urandom_range(0, span + 2 * eff_scale()));
  endfunction

  task automatic random_item();
    int pick, x1, y1, x2, y2, cell_val, t;
    pick = $urandom_range(0, 99);
    x1 = rand_x();
    y1 = rand_y();
    x2 = rand_x();
    y2 = rand_y();
    cell_val = $urandom_range(0, 255);
    if (pick < 30) begin
      if ($urandom_range(0, 9) != 0) begin
        x1 = int'($urandom_range(0, cols_in_use() + 1)) - 1;
        y1 = int'($urandom_range(0, rows_in_use() + 1)) - 1;
      end else begin
        x1 = rnd16();
        y1 = rnd16();
      end
      issue(ACT_WRITE, x1, y1, x2, y2, cell_val);
    end else if (pick < 50) begin
      // keep rectangles a few cells wide, except now and then on a small map
      if (cols_in_use() * rows_in_use() > 4096 || $urandom_range(0, 4) != 0) begin
        x2 = x1 + int'($urandom_range(0, 3 * eff_scale()));
        y2 = y1 - int'($urandom_range(0, 3 * eff_scale()));
        if ($urandom_range(0, 9) == 0) begin
          t = x1;
          x1 = x2;
          x2 = t;
        end
      end
      issue(ACT_BUMP, x1, y1, x2, y2, cell_val);
    end else if (pick < 75) begin
      issue(ACT_VERT, x1, y1, x2, y2, cell_val);
    end else begin
      issue(ACT_HORZ, x1, y1, x2, y2, cell_val);
    end
  endtask

  task automatic test_defaults();
    issue(ACT_HORZ, -32768, 0, 32767, rnd16(), 0);
    issue(ACT_WRITE, 1023, 1023, rnd16(), rnd16(), 255);
    issue(ACT_WRITE, 0, 0, rnd16(), rnd16(), 0);
    issue(ACT_WRITE, 1, 0, rnd16(), rnd16(), 255);
    issue(ACT_VERT, 32767, 32767, rnd16(), -32768, 0);
    // writes just and far outside the map
    issue(ACT_WRITE, -1, 5, rnd16(), rnd16(), 9);
    issue(ACT_WRITE, 1024, 0, rnd16(), rnd16(), 9);
    issue(ACT_WRITE, 5, -32768, rnd16(), rnd16(), 9);
    issue(ACT_WRITE, 32767, 32767, rnd16(), rnd16(), 9);
    issue(ACT_BUMP, 0, 0, 3, -3, 0);
    // empty rectangles: left past right, top past bottom
    issue(ACT_BUMP, 5, 0, 2, -3, 255);
    issue(ACT_BUMP, 0, -3, 3, 0, 255);
    issue(ACT_HORZ, 7, 0, 0, rnd16(), 0);
    issue(ACT_VERT, 3, -2, rnd16(), -2, 0);
    issue(ACT_HORZ, 4, -1, 4, rnd16(), 0);
    // bump on a full cell stays at the top
    issue(ACT_WRITE, 2, 2, rnd16(), rnd16(), 255);
    issue(ACT_BUMP, 2, -2, 2, -2, 0);
    issue(ACT_VERT, 2, 0, rnd16(), -6, 0);
    wait_results();
  endtask

  task automatic test_registers();
    // zero scale, one column, rows above range
    program_map(0, 32767, 0, 2047);
    issue(ACT_HORZ, -32768, rnd16(), 32767, rnd16(), 0);
    issue(ACT_BUMP, -32768, 32767, 32767, -32768, 0);
    issue(ACT_VERT, 32767, 32767, rnd16(), -32768, 0);
    issue(ACT_WRITE, 0, 1023, rnd16(), rnd16(), 200);
    issue(ACT_WRITE, 1, 0, rnd16(), rnd16(), 200);
    issue(ACT_VERT, 0, -32768, rnd16(), 32767, 0);
    wait_results();
    // largest scale, columns above range, one row
    program_map(31, 0, 2047, 1);
    issue(ACT_HORZ, -32768, rnd16(), 32767, rnd16(), 0);
    issue(ACT_VERT, rnd16(), -32768, rnd16(), 32767, 0);
    issue(ACT_BUMP, -32768, 32767, 32767, -32768, 0);
    issue(ACT_HORZ, 32767, 0, -32768, rnd16(), 0);
    wait_results();
    program_map(16, 20000, 1, 16);
    issue(ACT_BUMP, 0, 20000, 0, 19900, 0);
    issue(ACT_VERT, 15, 20000, rnd16(), 19700, 0);
    issue(ACT_HORZ, -15, 19990, 100, rnd16(), 0);
    wait_results();
  endtask

  // Alternating values along one row push the scaled distance into saturation
  task automatic test_saturation();
    int c;
    program_map(31, 0, 1024, 1024);
    for (c = 0; c < MAP_WIDTH; c += 2)
      issue(ACT_WRITE, c, 7, rnd16(), rnd16(), $urandom_range(1, 255));
    issue(ACT_HORZ, 0, -220, 32767, rnd16(), 0);
    issue(ACT_HORZ, 32767, -220, 0, rnd16(), 0);
    wait_results();
  endtask

  task automatic program_random_map();
    int scale, cols, rows;
    scale = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(0, 31);
    cols = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 48) : $urandom_range(0, 2047);
    rows = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 48) : $urandom_range(0, 2047);
    program_map(scale, $urandom_range(0, 32767), cols, rows);
  endtask

  task automatic test_random();
    int s, n;
    for (s = 0; s < 2; s++) begin
      wait_results();
      program_random_map();
      for (n = 0; n < 15; n++) random_item();
    end
    wait_results();
  endtask

  // Receiver holds off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    int n;
    program_map(2, 100, 32, 32);
    hold_req++;
    for (n = 0; n < 16; n++) random_item();
    wait_results();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    tx_idle_pct = 13;
    rx_idle_pct = 75;
    test_defaults();
    test_registers();
    test_random();
    tx_idle_pct = 75;
    rx_idle_pct = 13;
    test_saturation();
    test_random();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random();
    test_backpressure();
    wait_results();
    repeat (64) @(posedge clk_i);
    if (errors == 0) begin
      $display("projection_map_curved_distance verification clean");
    end else begin
      $display("projection_map_curved_distance verification failed");
    end
    $finish;
  end

  // Timeout guard; the map clear after reset alone sweeps all MEM_DEPTH cells
  initial begin
    #40_000_000;
    $display("projection_map_curved_distance verification failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
hw/rtl/pmcd_pkg.sv
hw/rtl/pmcd_div.sv
hw/rtl/pmcd_dp.sv
hw/rtl/pmcd_ctrl.sv
hw/rtl/projection_map_curved_distance.sv
bench/tb.sv
